// ===== hw/rtl/srp_pkg.sv =====
// shared constants, codes and types of the step-rate planner
`timescale 1ns / 1ps
`default_nettype none

package srp_pkg;

  // axes held in the error table
  localparam int AXES       = 3;
  localparam int AXIS_W     = 2;

  // field widths
  localparam int TICK_W     = 32;
  localparam int ERR_W      = 24;
  localparam int MAG_W      = 23;
  localparam int RATE_W     = 20;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 23;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  // squaring and division by the ramp divisor
  localparam int OP_W       = MAG_W;
  localparam int PROD_W     = 2 * OP_W;
  localparam int QUOT_W     = 33;
  localparam int REM_W      = 14;
  localparam int CNT_W      = $clog2(PROD_W);
  localparam logic [REM_W-1:0] RAMP_DIVISOR = REM_W'(10000);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE   = 2'd3;

  // register reset values
  localparam logic [MAG_W-1:0]  DEADBAND_RST   = MAG_W'(1500);
  localparam logic [MAG_W-1:0]  FULL_SPEED_RST = MAG_W'(23500);
  localparam logic [RATE_W-1:0] MIN_RATE_RST   = RATE_W'(1000);
  localparam logic [RATE_W-1:0] MAX_RATE_RST   = RATE_W'(50000);

  // action codes
  localparam logic [ACT_W-1:0] ACT_NONE      = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SERVO_OFF = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MOVE      = 2'd2;

  // request to the square and divide unit
  typedef struct packed {
    logic             start;
    logic [OP_W-1:0]  operand;
  } sq_req_t;

  // status back from the square and divide unit
  typedef struct packed {
    logic busy;
    logic done;
  } sq_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srp_sqdiv.sv =====
// bit-serial square of the ramp offset followed by restoring division by the ramp divisor
`timescale 1ns / 1ps
`default_nettype none

module srp_sqdiv (
  input  wire                          clk,
  input  wire                          rst_n,
  input  srp_pkg::sq_req_t             req,
  output srp_pkg::sq_stat_t            stat,
  output logic [srp_pkg::QUOT_W-1:0]   quotient
);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_DIV  = 2'd2;

  logic [1:0]                   phase_r, phase_nxt;
  logic [srp_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                         done_r, done_nxt;
  logic [srp_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic [srp_pkg::OP_W-1:0]     mcand_r;
  logic [srp_pkg::REM_W-1:0]    rem_r, rem_nxt;

  logic [srp_pkg::OP_W:0]       mul_sum;
  logic [srp_pkg::REM_W:0]      div_trial;
  logic [srp_pkg::REM_W:0]      div_diff;
  logic                         div_ge;

  // multiply: low half holds the unused multiplier bits, product grows in from the top
  assign mul_sum = {1'b0, prod_r[srp_pkg::PROD_W-1:srp_pkg::OP_W]}
                 + (prod_r[0] ? {1'b0, mcand_r} : '0);

  // divide: dividend leaves at the top, quotient bits enter at the bottom
  assign div_trial = {rem_r, prod_r[srp_pkg::PROD_W-1]};
  assign div_diff  = div_trial - {1'b0, srp_pkg::RAMP_DIVISOR};
  assign div_ge    = (div_trial >= {1'b0, srp_pkg::RAMP_DIVISOR});

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    case (phase_r)
      P_IDLE: begin
        if (req.start) begin
          phase_nxt = P_MUL;
          cnt_nxt   = '0;
          prod_nxt  = {{srp_pkg::OP_W{1'b0}}, req.operand};
          rem_nxt   = '0;
        end
      end
      P_MUL: begin
        prod_nxt = {mul_sum, prod_r[srp_pkg::OP_W-1:1]};
        if (cnt_r == srp_pkg::CNT_W'(srp_pkg::OP_W - 1)) begin
          phase_nxt = P_DIV;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      P_DIV: begin
        prod_nxt = {prod_r[srp_pkg::PROD_W-2:0], div_ge};
        rem_nxt  = div_ge ? div_diff[srp_pkg::REM_W-1:0] : div_trial[srp_pkg::REM_W-1:0];
        if (cnt_r == srp_pkg::CNT_W'(srp_pkg::PROD_W - 1)) begin
          phase_nxt = P_IDLE;
          done_nxt  = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        phase_nxt = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (phase_r == P_IDLE && req.start) begin
      mcand_r <= req.operand;
    end
  end

  assign stat.busy = (phase_r != P_IDLE);
  assign stat.done = done_r;
  assign quotient  = prod_r[srp_pkg::QUOT_W-1:0];

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held for more than one cycle");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> phase_r == P_IDLE)
    else $error("start while a ramp is in progress");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == P_DIV |-> rem_r < srp_pkg::RAMP_DIVISOR)
    else $error("partial remainder not below divisor");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> phase_r == P_IDLE)
    else $error("done while still busy");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/shared_step_rate_planner_top.sv =====
// top level of the shared step-rate planner: update decode, error table scan and ramp control
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake            payload
// in_       in   in_tvalid/in_tready  in_tdata 64 bit, in_tuser 1 bit
// out_      out  out_tvalid/out_tready out_tdata 48 bit, out_tuser 2 bit
// cfg_      in   cfg_we               cfg_index 2 bit, cfg_wdata 23 bit
//
// an update with no move goes from decode straight to the output register stage
// a move also passes the table scan and selection, and the ramp unit when it runs: the table scan
//   is one axis a cycle and the ramp unit squares in 23 single-bit steps and divides in
//   46 single-bit steps
// reset loads the register defaults and clears both per-axis tables at once
// a result waits in the output register; the next word is taken while it waits,
//   and processing stalls only when a second result is ready before the first is taken

module shared_step_rate_planner_top (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // axis_index, feedback_tick, pulse_error, up_allowed, down_allowed, zero fill
  input  wire  [srp_pkg::IN_DATA_W-1:0]      in_tdata,
  // error_valid
  input  wire                                in_tuser,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // target_axis, move_up, step_count, step_rate_hz, zero fill
  output logic [srp_pkg::OUT_DATA_W-1:0]     out_tdata,
  // action
  output logic [srp_pkg::ACT_W-1:0]          out_tuser,
  input  wire                                cfg_we,
  input  wire  [srp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [srp_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SEL    = 3'd3;
  localparam logic [2:0] S_RAMP   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_r, state_nxt;

  // configuration
  logic [srp_pkg::MAG_W-1:0]  deadband_r, full_speed_r;
  logic [srp_pkg::RATE_W-1:0] min_rate_r, max_rate_r;

  // per-axis tables
  logic [srp_pkg::TICK_W-1:0] last_tick_r [srp_pkg::AXES];
  logic [srp_pkg::MAG_W-1:0]  axis_mag_r  [srp_pkg::AXES];

  // latched update
  logic [srp_pkg::AXIS_W-1:0] axis_r;
  logic [srp_pkg::TICK_W-1:0] tick_r;
  logic [srp_pkg::ERR_W-1:0]  err_r;
  logic                       valid_r, up_ok_r, down_ok_r;

  // working values
  logic [srp_pkg::MAG_W-1:0]  cur_mag_r;
  logic [srp_pkg::MAG_W-1:0]  max_err_r;
  logic [srp_pkg::AXIS_W-1:0] scan_idx_r;
  logic [srp_pkg::ACT_W-1:0]  res_action_r;
  logic                       res_up_r;
  logic [srp_pkg::RATE_W-1:0] res_rate_r;

  // output register
  logic                       out_valid_r;
  logic [srp_pkg::AXIS_W-1:0] out_axis_r;
  logic [srp_pkg::ACT_W-1:0]  out_action_r;
  logic                       out_up_r;
  logic [srp_pkg::MAG_W-1:0]  out_count_r;
  logic [srp_pkg::RATE_W-1:0] out_rate_r;

  logic                       in_fire, out_load;
  logic                       axis_ok, tick_new, err_nonzero, err_neg, dir_ok;
  logic [srp_pkg::ERR_W-1:0]  err_abs;
  logic [srp_pkg::MAG_W-1:0]  mag_c;
  logic [srp_pkg::MAG_W-1:0]  ramp_err;
  logic [srp_pkg::RATE_W-1:0] min_capped;
  logic [srp_pkg::QUOT_W:0]   ramp_sum;
  logic [srp_pkg::RATE_W-1:0] ramp_rate;

  srp_pkg::sq_req_t           sq_req;
  srp_pkg::sq_stat_t          sq_stat;
  logic [srp_pkg::QUOT_W-1:0] sq_quot;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // decode of the latched update
  assign axis_ok     = (axis_r < srp_pkg::AXIS_W'(srp_pkg::AXES));
  assign tick_new    = axis_ok && (tick_r != last_tick_r[axis_r]);
  assign err_nonzero = (err_r != '0);
  assign err_neg     = err_r[srp_pkg::ERR_W-1];
  assign err_abs     = err_neg ? (~err_r + 1'b1) : err_r;
  // the most negative error saturates
  assign mag_c       = err_abs[srp_pkg::ERR_W-1] ? '1 : err_abs[srp_pkg::MAG_W-1:0];
  assign dir_ok      = err_neg ? down_ok_r : up_ok_r;

  // the ramp never falls as the error grows, so the lesser of the two ramps is the
  // ramp of the lesser error
  assign ramp_err   = (max_err_r < cur_mag_r) ? max_err_r : cur_mag_r;
  assign min_capped = (min_rate_r > max_rate_r) ? max_rate_r : min_rate_r;
  assign ramp_sum   = {1'b0, sq_quot} + (srp_pkg::QUOT_W + 1)'(min_rate_r);
  assign ramp_rate  = (ramp_sum > (srp_pkg::QUOT_W + 1)'(max_rate_r))
                    ? max_rate_r : ramp_sum[srp_pkg::RATE_W-1:0];

  assign sq_req.start   = (state_r == S_SEL) && (ramp_err < full_speed_r)
                        && (ramp_err > deadband_r);
  assign sq_req.operand = ramp_err - deadband_r;

  srp_sqdiv u_sqdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (sq_req),
    .stat     (sq_stat),
    .quotient (sq_quot)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (tick_new && valid_r && err_nonzero && (mag_c >= deadband_r) && dir_ok) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SCAN: begin
        if (scan_idx_r == srp_pkg::AXIS_W'(srp_pkg::AXES - 1)) begin
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        state_nxt = sq_req.start ? S_RAMP : S_OUT;
      end
      S_RAMP: begin
        if (sq_stat.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state, configuration and tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      deadband_r   <= srp_pkg::DEADBAND_RST;
      full_speed_r <= srp_pkg::FULL_SPEED_RST;
      min_rate_r   <= srp_pkg::MIN_RATE_RST;
      max_rate_r   <= srp_pkg::MAX_RATE_RST;
      for (int i = 0; i < srp_pkg::AXES; i++) begin
        last_tick_r[i] <= '0;
        axis_mag_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          srp_pkg::REG_DEADBAND:   deadband_r   <= cfg_wdata[srp_pkg::MAG_W-1:0];
          srp_pkg::REG_FULL_SPEED: full_speed_r <= cfg_wdata[srp_pkg::MAG_W-1:0];
          srp_pkg::REG_MIN_RATE:   min_rate_r   <= cfg_wdata[srp_pkg::RATE_W-1:0];
          srp_pkg::REG_MAX_RATE:   max_rate_r   <= cfg_wdata[srp_pkg::RATE_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_DECIDE && tick_new) begin
        last_tick_r[axis_r] <= tick_r;
        if (valid_r && err_nonzero) begin
          axis_mag_r[axis_r] <= mag_c;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      axis_r    <= in_tdata[1:0];
      tick_r    <= in_tdata[33:2];
      err_r     <= in_tdata[57:34];
      up_ok_r   <= in_tdata[58];
      down_ok_r <= in_tdata[59];
      valid_r   <= in_tuser;
    end
    case (state_r)
      S_DECIDE: begin
        cur_mag_r  <= mag_c;
        res_up_r   <= !err_neg;
        res_rate_r <= '0;
        max_err_r  <= '0;
        scan_idx_r <= '0;
        if (tick_new && valid_r && err_nonzero) begin
          if (mag_c < deadband_r) begin
            res_action_r <= srp_pkg::ACT_SERVO_OFF;
          end else if (dir_ok) begin
            res_action_r <= srp_pkg::ACT_MOVE;
          end else begin
            res_action_r <= srp_pkg::ACT_NONE;
          end
        end else begin
          res_action_r <= srp_pkg::ACT_NONE;
        end
      end
      S_SCAN: begin
        if (axis_mag_r[scan_idx_r] > max_err_r) begin
          max_err_r <= axis_mag_r[scan_idx_r];
        end
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      S_SEL: begin
        if (ramp_err >= full_speed_r) begin
          res_rate_r <= max_rate_r;
        end else if (ramp_err <= deadband_r) begin
          res_rate_r <= min_capped;
        end
      end
      S_RAMP: begin
        if (sq_stat.done) begin
          res_rate_r <= ramp_rate;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_axis_r   <= axis_r;
      out_action_r <= res_action_r;
      if (res_action_r == srp_pkg::ACT_MOVE) begin
        out_up_r    <= res_up_r;
        out_count_r <= cur_mag_r;
        out_rate_r  <= res_rate_r;
      end else begin
        out_up_r    <= 1'b0;
        out_count_r <= '0;
        out_rate_r  <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_action_r;
  assign out_tdata  = {2'b00, out_rate_r, out_count_r, out_up_r, out_axis_r};

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_DECIDE)
    else $error("accepted word not taken into decode");

  a_ramp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RAMP && !sq_stat.done) |-> sq_stat.busy)
    else $error("waiting on ramp unit that is not running");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action_r != srp_pkg::ACT_MOVE) |->
      (out_rate_r == '0 && out_count_r == '0 && !out_up_r))
    else $error("non-move result carries move fields");

  a_rate_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action_r == srp_pkg::ACT_MOVE && $past(out_load)) |->
      out_rate_r <= $past(max_rate_r))
    else $error("move rate above ceiling");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_shared_step_rate_planner_top.sv =====
// self-checking testbench for the shared step-rate planner: directed table, then randomised phases
`timescale 1ns / 1ps

module tb_shared_step_rate_planner_top;
  import srp_pkg::*;

  localparam int PHASES        = 7;
  localparam int PHASE_UPDATES = 200;
  localparam int SETTLE_CYCLES = 100;
  localparam int TAIL_CYCLES   = 200;
  localparam int WATCH_LIMIT   = 5000;
  localparam int MAG_MAX       = 8388607;

  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    logic [TICK_W-1:0] tick;
    logic [ERR_W-1:0]  err;
    logic              valid;
    logic              up_ok;
    logic              down_ok;
  } update_t;

  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    logic [ACT_W-1:0]  act;
    logic              up;
    logic [MAG_W-1:0]  count;
    logic [RATE_W-1:0] rate;
  } command_t;

  typedef struct {
    update_t  upd;
    logic     typed;
    command_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [ACT_W-1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // local copy of the planner registers and per-axis tables
  logic [MAG_W-1:0]  db_pulses = DEADBAND_RST;
  logic [MAG_W-1:0]  fs_pulses = FULL_SPEED_RST;
  logic [RATE_W-1:0] min_hz = MIN_RATE_RST;
  logic [RATE_W-1:0] max_hz = MAX_RATE_RST;
  logic [TICK_W-1:0] tick_seen [AXES];
  logic [MAG_W-1:0]  err_mag [AXES];

  command_t   pending_cmds [$];
  table_row_t steps [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  int n_sent = 0;
  int n_directed = 0;
  int n_checked = 0;
  int n_moves = 0;
  int n_servo = 0;
  int n_fail = 0;
  int n_settings = 1;

  shared_step_rate_planner_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // quadratic ramp, capped at the maximum rate
  function automatic logic [RATE_W-1:0] ramp_hz(logic [MAG_W-1:0] e);
    logic [63:0] r;
    logic [63:0] d;
    if (e >= fs_pulses) begin
      r = 64'(max_hz);
    end else if (e <= db_pulses) begin
      r = 64'(min_hz);
    end else begin
      d = 64'(e - db_pulses);
      r = d * d / 64'(RAMP_DIVISOR) + 64'(min_hz);
    end
    if (r > 64'(max_hz)) r = 64'(max_hz);
    return r[RATE_W-1:0];
  endfunction

  // predicts the command for one update and advances the per-axis tables
  function automatic command_t plan_update(update_t u);
    command_t c;
    logic [ERR_W-1:0] m24;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] peak;
    logic [RATE_W-1:0] shared_hz;
    logic [RATE_W-1:0] own_hz;
    logic neg;
    c = '0;
    c.axis = u.axis;
    if (u.axis < AXES) begin
      if (u.tick != tick_seen[u.axis]) begin
        tick_seen[u.axis] = u.tick;
        if (u.valid && u.err != '0) begin
          neg = u.err[ERR_W-1];
          m24 = neg ? -u.err : u.err;
          // only the most negative error leaves bit 23 set: saturate
          mag = m24[ERR_W-1] ? '1 : m24[MAG_W-1:0];
          err_mag[u.axis] = mag;
          if (mag < db_pulses) begin
            c.act = ACT_SERVO_OFF;
          end else if (neg ? u.down_ok : u.up_ok) begin
            peak = '0;
            for (int i = 0; i < AXES; i++) begin
              if (err_mag[i] > peak) peak = err_mag[i];
            end
            shared_hz = ramp_hz(peak);
            own_hz = ramp_hz(mag);
            c.act = ACT_MOVE;
            c.up = !neg;
            c.count = mag;
            c.rate = (shared_hz < own_hz) ? shared_hz : own_hz;
          end
        end
      end
    end
    return c;
  endfunction

  function automatic update_t mk(int axis, logic [TICK_W-1:0] tick, int err,
                                 bit valid, bit up_ok, bit down_ok);
    update_t u;
    u.axis = AXIS_W'(axis);
    u.tick = tick;
    u.err = ERR_W'(err);
    u.valid = valid;
    u.up_ok = up_ok;
    u.down_ok = down_ok;
    return u;
  endfunction

  function automatic command_t cmd(int axis, logic [ACT_W-1:0] act, bit up, int count, int rate);
    command_t c;
    c.axis = AXIS_W'(axis);
    c.act = act;
    c.up = up;
    c.count = MAG_W'(count);
    c.rate = RATE_W'(rate);
    return c;
  endfunction

  function automatic int near(int centre);
    int v;
    v = centre + int'($urandom_range(128)) - 64;
    if (v < 0) v = 0;
    if (v > MAG_MAX) v = MAG_MAX;
    return v;
  endfunction

  // mostly fresh, valid updates with errors around the deadband, the ramp and full speed
  function automatic update_t rand_update();
    update_t u;
    int unsigned sel;
    int mag;
    logic neg;
    u.axis = ($urandom_range(99) < 4) ? 2'd3 : AXIS_W'($urandom_range(AXES - 1));
    if (u.axis < AXES && $urandom_range(99) < 12) u.tick = tick_seen[u.axis];
    else u.tick = $urandom();
    u.valid = ($urandom_range(99) < 92);
    u.up_ok = ($urandom_range(99) < 80);
    u.down_ok = ($urandom_range(99) < 80);
    neg = $urandom_range(1);
    sel = $urandom_range(99);
    if (sel < 3) begin
      u.err = '0;
    end else if (sel < 6) begin
      u.err = {1'b1, {(ERR_W-1){1'b0}}};
    end else if (sel < 75) begin
      if (sel < 25) mag = near(int'(db_pulses));
      else if (sel < 40) mag = near(int'(fs_pulses));
      else mag = int'($urandom_range(db_pulses, fs_pulses));
      u.err = neg ? -ERR_W'(mag) : ERR_W'(mag);
    end else begin
      u.err = ERR_W'($urandom());
    end
    return u;
  endfunction

  task automatic send_update(update_t u, logic typed, command_t want);
    command_t c;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    // four bits of zero fill above down_allowed
    in_tdata <= {4'b0000, u.down_ok, u.up_ok, u.err, u.tick, u.axis};
    in_tuser <= u.valid;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    c = plan_update(u);
    pending_cmds.push_back(typed ? want : c);
    n_sent++;
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEADBAND:   db_pulses = MAG_W'(val);
      REG_FULL_SPEED: fs_pulses = MAG_W'(val);
      REG_MIN_RATE:   min_hz = RATE_W'(val);
      REG_MAX_RATE:   max_hz = RATE_W'(val);
      default: ;
    endcase
  endtask

  task automatic load_regs(int unsigned db, int unsigned fs, int unsigned mn, int unsigned mx);
    set_reg(REG_DEADBAND, db);
    set_reg(REG_FULL_SPEED, fs);
    set_reg(REG_MIN_RATE, mn);
    set_reg(REG_MAX_RATE, mx);
    n_settings++;
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    command_t got;
    command_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.axis = out_tdata[1:0];
      got.up = out_tdata[2];
      got.count = out_tdata[25:3];
      got.rate = out_tdata[45:26];
      got.act = out_tuser;
      if (pending_cmds.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("%0t: unexpected word axis %0d action %0d", $realtime, got.axis, got.act);
      end else begin
        want = pending_cmds.pop_front();
        n_checked++;
        if (got.act == ACT_MOVE) n_moves++;
        if (got.act == ACT_SERVO_OFF) n_servo++;
        if (got.axis !== want.axis || got.act !== want.act || got.up !== want.up ||
            got.count !== want.count || got.rate !== want.rate) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: mismatch exp axis %0d act %0d up %0d count %0d rate %0d, got %0d %0d %0d %0d %0d",
                     $realtime, want.axis, want.act, want.up, want.count, want.rate,
                     got.axis, got.act, got.up, got.count, got.rate);
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < AXES; i++) begin
      tick_seen[i] = '0;
      err_mag[i] = '0;
    end

    // same tick as after reset, out-of-range axis, invalid, zero error
    steps.push_back('{mk(0, 0, 5000, 1, 1, 1), 1'b1, cmd(0, ACT_NONE, 0, 0, 0)});
    steps.push_back('{mk(3, 7, 5000, 1, 1, 1), 1'b1, cmd(3, ACT_NONE, 0, 0, 0)});
    steps.push_back('{mk(0, 1, 5000, 0, 1, 1), 1'b1, cmd(0, ACT_NONE, 0, 0, 0)});
    steps.push_back('{mk(0, 2, 0, 1, 1, 1), 1'b1, cmd(0, ACT_NONE, 0, 0, 0)});
    steps.push_back('{mk(0, 3, 100, 1, 1, 1), 1'b1, cmd(0, ACT_SERVO_OFF, 0, 0, 0)});
    steps.push_back('{mk(1, 1, 23500, 1, 1, 0), 1'b1, cmd(1, ACT_MOVE, 1, 23500, 50000)});
    // most negative error saturates
    steps.push_back('{mk(2, 1, -8388608, 1, 0, 1), 1'b1, cmd(2, ACT_MOVE, 0, MAG_MAX, 50000)});
    steps.push_back('{mk(2, 2, MAG_MAX, 1, 0, 1), 1'b1, cmd(2, ACT_NONE, 0, 0, 0)});
    // own error at the deadband keeps the minimum rate
    steps.push_back('{mk(0, 4, 1500, 1, 1, 0), 1'b1, cmd(0, ACT_MOVE, 1, 1500, 1000)});
    steps.push_back('{mk(0, 5, -1499, 1, 1, 1), 1'b1, cmd(0, ACT_SERVO_OFF, 0, 0, 0)});
    steps.push_back('{mk(1, 2, 11500, 1, 1, 1), 1'b1, cmd(1, ACT_MOVE, 1, 11500, 11000)});
    steps.push_back('{mk(1, 2, -300, 1, 1, 1), 1'b1, cmd(1, ACT_NONE, 0, 0, 0)});
    steps.push_back('{mk(0, 32'hFFFF_FFFF, -1, 1, 1, 1), 1'b1, cmd(0, ACT_SERVO_OFF, 0, 0, 0)});
    steps.push_back('{mk(2, 3, -MAG_MAX, 1, 1, 0), 1'b1, cmd(2, ACT_NONE, 0, 0, 0)});
    steps.push_back('{mk(1, 3, 23499, 1, 1, 1), 1'b0, command_t'('0)});
    steps.push_back('{mk(2, 4, -20000, 1, 1, 1), 1'b0, command_t'('0)});
    steps.push_back('{mk(0, 6, 1501, 1, 1, 1), 1'b0, command_t'('0)});
    steps.push_back('{mk(1, 4, -12345, 1, 0, 1), 1'b0, command_t'('0)});
    steps.push_back('{mk(2, 5, 1, 1, 1, 1), 1'b1, cmd(2, ACT_SERVO_OFF, 0, 0, 0)});
    steps.push_back('{mk(2, 6, 5, 0, 0, 0), 1'b1, cmd(2, ACT_NONE, 0, 0, 0)});
    steps.push_back('{mk(0, 32'hAAAA_AAAA, 24'h555555, 1, 1, 1), 1'b0, command_t'('0)});
    steps.push_back('{mk(1, 32'h5555_5555, -5592406, 1, 1, 1), 1'b0, command_t'('0)});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) send_update(steps[i].upd, steps[i].typed, steps[i].want);
    n_directed = n_sent;

    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      case (p)
        1: load_regs(0, MAG_MAX, 0, 1000000);
        // full speed below the deadband, minimum above a zero maximum
        2: load_regs(MAG_MAX, 0, 1000000, 0);
        3: load_regs($urandom_range(5000), 0, $urandom_range(5000), $urandom_range(1000000, 10000));
        4: load_regs(100, 100, 60000, 20000);
        5: load_regs($urandom_range(MAG_MAX), $urandom_range(MAG_MAX),
                     $urandom_range(1000000), $urandom_range(1000000));
        6: load_regs(1500, 23500, 1000, 50000);
        default: ;
      endcase
      // random ramp span for the moderate setting
      if (p == 3) set_reg(REG_FULL_SPEED, int'(db_pulses) + $urandom_range(40000, 1));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      repeat (PHASE_UPDATES) send_update(rand_update(), 1'b0, command_t'('0));
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d updates (%0d from the table) over %0d register settings and four pacing modes",
             n_sent, n_directed, n_settings);
    $display("checked %0d commands: %0d moves, %0d servo-off, %0d with no action",
             n_checked, n_moves, n_servo, n_checked - n_moves - n_servo);
    if (n_fail == 0 && pending_cmds.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
